// ----- rtl/regime_weighted_arma_generator_unit_assert.svh -----
// Assertion macros shared by several RTL files of the ARMA generator.
`ifndef REGIME_WEIGHTED_ARMA_GENERATOR_UNIT_ASSERT_SVH
`define REGIME_WEIGHTED_ARMA_GENERATOR_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RWAG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RWAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rwag_pkg.sv -----
`default_nettype none

package rwag_pkg;

    // Model dimensions.
    localparam int MAX_REGIMES    = 4;
    localparam int AR_TAPS        = 8;
    localparam int MA_TAPS        = 8;
    localparam int SHARED_MA_TAPS = 8;

    localparam int REGIME_STRIDE = AR_TAPS + MA_TAPS;
    localparam int SHARED_BASE   = MAX_REGIMES * REGIME_STRIDE;
    localparam int TABLE_SIZE    = SHARED_BASE + SHARED_MA_TAPS;
    localparam int SHOCK_DEPTH   = (MA_TAPS > SHARED_MA_TAPS) ? MA_TAPS : SHARED_MA_TAPS;
    localparam int TAP_SPAN      = (REGIME_STRIDE > SHARED_MA_TAPS) ? REGIME_STRIDE
                                                                    : SHARED_MA_TAPS;

    // Index widths.
    localparam int REGIME_W     = (MAX_REGIMES > 1) ? $clog2(MAX_REGIMES) : 1;
    localparam int AR_IDX_W     = (AR_TAPS > 1) ? $clog2(AR_TAPS) : 1;
    localparam int SHOCK_IDX_W  = (SHOCK_DEPTH > 1) ? $clog2(SHOCK_DEPTH) : 1;
    localparam int TAP_W        = (TAP_SPAN > 1) ? $clog2(TAP_SPAN) : 1;
    localparam int TABLE_ADDR_W = $clog2(TABLE_SIZE);

    // Field and datapath widths.
    localparam int COEF_IDX_W = 7;
    localparam int DATA_W     = 32;
    localparam int WEIGHT_W   = 17;
    localparam int FRAC_W     = 16;
    localparam int OPND_W     = 34;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ACC_W      = 64;
    localparam int S_W        = 53;
    localparam int SPLIT_W    = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGIME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_ADJUST  = 1'd1;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHARED,
        ST_TAPS,
        ST_BUBBLE,
        ST_WEIGHT_HI,
        ST_WEIGHT_LO,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        KIND_SHARED_TAP,
        KIND_REGIME_TAP,
        KIND_WEIGHT_HI,
        KIND_WEIGHT_LO
    } issue_kind_t;

    // One operation issued to the shared multiplier.
    typedef struct packed {
        logic                    valid;
        issue_kind_t             kind;
        logic [REGIME_W-1:0]     regime;
        logic [TAP_W-1:0]        tap;
        logic [TABLE_ADDR_W-1:0] coef_addr;
    } issue_t;

    // Sequencer controls to the datapath.
    typedef struct packed {
        logic                busy;
        logic                clear;
        logic                s_init;
        logic [REGIME_W-1:0] s_regime;
        logic                finish;
    } seq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rwag_coef_mem.sv -----
`default_nettype none
`include "regime_weighted_arma_generator_unit_assert.svh"

module rwag_coef_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [rwag_pkg::TABLE_ADDR_W-1:0] wr_addr,
    input  logic [rwag_pkg::DATA_W-1:0]       wr_data,
    input  logic                              rd_en,
    input  logic [rwag_pkg::TABLE_ADDR_W-1:0] rd_addr,
    output logic [rwag_pkg::DATA_W-1:0]       rd_data
);
    import rwag_pkg::*;

    logic [DATA_W-1:0] mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic rd_valid_reg;

    // Coefficient storage; written by a write transfer.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    // Writes only happen while idle, never during a tap read.
    `RWAG_ASSERT_SAME(a_no_rw_overlap, clk, rst_n, wr_en, !rd_en,
        "coefficient write during a tap read")

endmodule

`default_nettype wire

// ----- rtl/rwag_history.sv -----
`default_nettype none

module rwag_history (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rwag_pkg::issue_t              issue,
    input  logic                          mean_adjust,
    input  logic                          finish,
    input  logic [rwag_pkg::DATA_W-1:0]   new_output,
    input  logic [rwag_pkg::DATA_W-1:0]   new_mean [rwag_pkg::MAX_REGIMES],
    input  logic [rwag_pkg::DATA_W-1:0]   new_shock,
    output logic signed [rwag_pkg::OPND_W-1:0] operand
);
    import rwag_pkg::*;

    logic [DATA_W-1:0] out_hist_reg   [AR_TAPS];
    logic [DATA_W-1:0] shock_hist_reg [SHOCK_DEPTH];
    logic [DATA_W-1:0] mean_hist_reg  [MAX_REGIMES][AR_TAPS];

    logic [AR_IDX_W-1:0]    ar_idx;
    logic [TAP_W-1:0]       ma_tap;
    logic [SHOCK_IDX_W-1:0] ma_idx;
    logic [SHOCK_IDX_W-1:0] sh_idx;
    logic [DATA_W:0]        y_ext;
    logic [DATA_W:0]        m_ext;
    logic [DATA_W:0]        diff;
    logic [DATA_W-1:0]      e_sel;

    // Shift lines advance once per time step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < AR_TAPS; j++)
            begin
                out_hist_reg[j] <= '0;
                for (int k = 0; k < MAX_REGIMES; k++)
                begin
                    mean_hist_reg[k][j] <= '0;
                end
            end
            for (int j = 0; j < SHOCK_DEPTH; j++)
            begin
                shock_hist_reg[j] <= '0;
            end
        end
        else if (finish)
        begin
            for (int j = AR_TAPS - 1; j > 0; j--)
            begin
                out_hist_reg[j] <= out_hist_reg[j-1];
                for (int k = 0; k < MAX_REGIMES; k++)
                begin
                    mean_hist_reg[k][j] <= mean_hist_reg[k][j-1];
                end
            end
            out_hist_reg[0] <= new_output;
            for (int k = 0; k < MAX_REGIMES; k++)
            begin
                mean_hist_reg[k][0] <= new_mean[k];
            end
            for (int j = SHOCK_DEPTH - 1; j > 0; j--)
            begin
                shock_hist_reg[j] <= shock_hist_reg[j-1];
            end
            shock_hist_reg[0] <= new_shock;
        end
    end

    // Operand for the issued tap: past output less the optional past mean,
    // or a past shock.
    always_comb
    begin
        ar_idx = issue.tap[AR_IDX_W-1:0];
        ma_tap = issue.tap - TAP_W'(AR_TAPS);
        ma_idx = ma_tap[SHOCK_IDX_W-1:0];
        sh_idx = issue.tap[SHOCK_IDX_W-1:0];
        y_ext  = {out_hist_reg[ar_idx][DATA_W-1], out_hist_reg[ar_idx]};
        if (mean_adjust)
        begin
            m_ext = {mean_hist_reg[issue.regime][ar_idx][DATA_W-1],
                     mean_hist_reg[issue.regime][ar_idx]};
        end
        else
        begin
            m_ext = '0;
        end
        diff  = y_ext - m_ext;
        e_sel = shock_hist_reg[sh_idx];
        operand = '0;
        case (issue.kind)
            KIND_REGIME_TAP:
            begin
                if (issue.tap < TAP_W'(AR_TAPS))
                begin
                    operand = {{(OPND_W-DATA_W-1){diff[DATA_W]}}, diff};
                end
                else
                begin
                    e_sel   = shock_hist_reg[ma_idx];
                    operand = {{(OPND_W-DATA_W){e_sel[DATA_W-1]}}, e_sel};
                end
            end
            KIND_SHARED_TAP:
            begin
                operand = {{(OPND_W-DATA_W){e_sel[DATA_W-1]}}, e_sel};
            end
            default:
            begin
                operand = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rwag_mac.sv -----
`default_nettype none

module rwag_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rwag_pkg::issue_t              issue,
    input  rwag_pkg::seq_ctrl_t           ctrl,
    input  logic signed [rwag_pkg::OPND_W-1:0] hist_operand,
    input  logic [rwag_pkg::DATA_W-1:0]   coef,
    input  logic [rwag_pkg::WEIGHT_W-1:0] weight [rwag_pkg::MAX_REGIMES],
    input  logic [rwag_pkg::DATA_W-1:0]   mean   [rwag_pkg::MAX_REGIMES],
    input  logic [rwag_pkg::DATA_W-1:0]   shock,
    output logic [rwag_pkg::DATA_W-1:0]   result_value,
    output logic                          result_sat
);
    import rwag_pkg::*;

    // Issue stage registers.
    logic signed [OPND_W-1:0] opnd_reg;
    logic [WEIGHT_W-1:0]      wsel_reg;
    logic                     tag1_valid_reg;
    issue_kind_t              tag1_kind_reg;

    // Multiply stage registers.
    logic signed [PROD_W-1:0] prod_reg;
    logic                     tag2_valid_reg;
    issue_kind_t              tag2_kind_reg;

    // Accumulators: regime sum and output total.
    logic signed [ACC_W-1:0] s_reg;
    logic signed [ACC_W-1:0] s_next;
    logic signed [ACC_W-1:0] total_reg;
    logic signed [ACC_W-1:0] total_next;

    logic signed [OPND_W-1:0] opnd_next;
    logic signed [OPND_W-1:0] mult_a;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [ACC_W-1:0]  term_floor;
    logic signed [ACC_W-1:0]  term_high;
    logic [DATA_W-1:0]        mean_sel;

    // Operand selection: history value, or one half of the regime sum.
    always_comb
    begin
        case (issue.kind)
            KIND_WEIGHT_HI:
            begin
                opnd_next = {{(OPND_W-(S_W-SPLIT_W)){s_reg[S_W-1]}},
                             s_reg[S_W-1:SPLIT_W]};
            end
            KIND_WEIGHT_LO:
            begin
                opnd_next = {{(OPND_W-SPLIT_W){1'b0}}, s_reg[SPLIT_W-1:0]};
            end
            default:
            begin
                opnd_next = hist_operand;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            opnd_reg <= opnd_next;
            wsel_reg <= weight[issue.regime];
        end
    end

    // The shared multiplier: coefficient or weight times the operand.
    always_comb
    begin
        if (tag1_kind_reg == KIND_WEIGHT_HI || tag1_kind_reg == KIND_WEIGHT_LO)
        begin
            mult_a = {{(OPND_W-WEIGHT_W){1'b0}}, wsel_reg};
        end
        else
        begin
            mult_a = {{(OPND_W-DATA_W){coef[DATA_W-1]}}, coef};
        end
        prod_next = PROD_W'(mult_a) * PROD_W'(opnd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (tag1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    // Pipeline tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_valid_reg <= 1'b0;
            tag1_kind_reg  <= KIND_SHARED_TAP;
            tag2_valid_reg <= 1'b0;
            tag2_kind_reg  <= KIND_SHARED_TAP;
        end
        else
        begin
            tag1_valid_reg <= issue.valid;
            tag1_kind_reg  <= issue.kind;
            tag2_valid_reg <= tag1_valid_reg;
            tag2_kind_reg  <= tag1_kind_reg;
        end
    end

    // Accumulate: products are floored after the 16-bit scale; the upper
    // half of a split weight product is exact, so it is scaled up instead.
    always_comb
    begin
        prod_shr   = prod_reg >>> FRAC_W;
        term_floor = prod_shr[ACC_W-1:0];
        term_high  = {prod_reg[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        mean_sel   = mean[ctrl.s_regime];
        s_next     = s_reg;
        total_next = total_reg;
        if (tag2_valid_reg)
        begin
            case (tag2_kind_reg)
                KIND_REGIME_TAP: s_next     = s_reg + term_floor;
                KIND_SHARED_TAP: total_next = total_reg + term_floor;
                KIND_WEIGHT_LO:  total_next = total_reg + term_floor;
                KIND_WEIGHT_HI:  total_next = total_reg + term_high;
                default:         total_next = total_reg;
            endcase
        end
        if (ctrl.s_init)
        begin
            s_next = {{(ACC_W-DATA_W){mean_sel[DATA_W-1]}}, mean_sel};
        end
        if (ctrl.clear)
        begin
            total_next = {{(ACC_W-DATA_W){shock[DATA_W-1]}}, shock};
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        total_reg <= total_next;
    end

    // Saturate the total to the signed 32-bit range.
    always_comb
    begin
        result_sat = !((&total_reg[ACC_W-1:DATA_W-1]) || (~|total_reg[ACC_W-1:DATA_W-1]));
        if (result_sat)
        begin
            result_value = total_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                              : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            result_value = total_reg[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rwag_seq.sv -----
`default_nettype none
`include "regime_weighted_arma_generator_unit_assert.svh"

module rwag_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start_step,
    input  logic [rwag_pkg::CFG_DATA_W-1:0] regime_count,
    input  logic                            out_free,
    output rwag_pkg::issue_t                issue,
    output rwag_pkg::seq_ctrl_t             ctrl
);
    import rwag_pkg::*;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [TAP_W-1:0]    tap_reg;
    logic [TAP_W-1:0]    tap_next;
    logic [REGIME_W-1:0] regime_reg;
    logic [REGIME_W-1:0] regime_next;
    logic                wait_reg;
    logic                wait_next;
    logic [REGIME_W-1:0] regime_last;

    // Last active regime; zero counts as one, large counts are clamped.
    always_comb
    begin
        if (regime_count == '0)
        begin
            regime_last = '0;
        end
        else if (int'(regime_count) >= MAX_REGIMES)
        begin
            regime_last = REGIME_W'(MAX_REGIMES - 1);
        end
        else
        begin
            regime_last = REGIME_W'(regime_count - CFG_DATA_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tap_reg    <= '0;
            regime_reg <= '0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tap_reg    <= tap_next;
            regime_reg <= regime_next;
            wait_reg   <= wait_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        regime_next = regime_reg;
        wait_next   = wait_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_step)
                begin
                    state_next = ST_SHARED;
                    tap_next   = '0;
                end
            end
            ST_SHARED:
            begin
                if (tap_reg == TAP_W'(SHARED_MA_TAPS - 1))
                begin
                    state_next  = ST_TAPS;
                    tap_next    = '0;
                    regime_next = '0;
                end
                else
                begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            ST_TAPS:
            begin
                if (tap_reg == TAP_W'(REGIME_STRIDE - 1))
                begin
                    state_next = ST_BUBBLE;
                    wait_next  = 1'b0;
                end
                else
                begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            ST_BUBBLE:
            begin
                if (wait_reg)
                begin
                    state_next = ST_WEIGHT_HI;
                end
                else
                begin
                    wait_next = 1'b1;
                end
            end
            ST_WEIGHT_HI:
            begin
                state_next = ST_WEIGHT_LO;
            end
            ST_WEIGHT_LO:
            begin
                if (regime_reg == regime_last)
                begin
                    state_next = ST_DRAIN;
                    wait_next  = 1'b0;
                end
                else
                begin
                    state_next  = ST_TAPS;
                    regime_next = regime_reg + REGIME_W'(1);
                    tap_next    = '0;
                end
            end
            ST_DRAIN:
            begin
                if (wait_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wait_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Issue and datapath controls for each state.
    always_comb
    begin
        issue.valid     = 1'b0;
        issue.kind      = KIND_SHARED_TAP;
        issue.regime    = regime_reg;
        issue.tap       = tap_reg;
        issue.coef_addr = TABLE_ADDR_W'(int'(regime_reg) * REGIME_STRIDE + int'(tap_reg));
        ctrl.busy       = (state_reg != ST_IDLE);
        ctrl.clear      = 1'b0;
        ctrl.s_init     = 1'b0;
        ctrl.s_regime   = '0;
        ctrl.finish     = 1'b0;
        case (state_reg)
            ST_SHARED:
            begin
                issue.valid     = 1'b1;
                issue.kind      = KIND_SHARED_TAP;
                issue.coef_addr = TABLE_ADDR_W'(SHARED_BASE + int'(tap_reg));
                ctrl.clear      = (tap_reg == '0);
                ctrl.s_init     = 1'b1;
            end
            ST_TAPS:
            begin
                issue.valid = 1'b1;
                issue.kind  = KIND_REGIME_TAP;
            end
            ST_WEIGHT_HI:
            begin
                issue.valid = 1'b1;
                issue.kind  = KIND_WEIGHT_HI;
            end
            ST_WEIGHT_LO:
            begin
                issue.valid = 1'b1;
                issue.kind  = KIND_WEIGHT_LO;
                if (regime_reg != regime_last)
                begin
                    ctrl.s_init   = 1'b1;
                    ctrl.s_regime = regime_reg + REGIME_W'(1);
                end
            end
            ST_DONE:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                issue.valid = 1'b0;
            end
        endcase
    end

    // A result is only loaded when the output register can take it.
    `RWAG_ASSERT_SAME(a_finish_free, clk, rst_n, ctrl.finish, out_free,
        "result loaded while the output register is occupied")

endmodule

`default_nettype wire

// ----- rtl/regime_weighted_arma_generator_unit.sv -----
// Coefficient write: gives no result. Time step: the input stays stalled until the result
// loads into the output register, and the next item can be taken in the cycle after that.
// One shared 34x34 multiplier computes every product: 8 shared taps, then 16 taps plus two
// weight products per regime, with a bubble state ahead of each regime's weight products.
// Asynchronous active-low reset clears the coefficient table, histories and sequencer;
// regime_count resets to 1, mean_adjust to 0.
`default_nettype none
`include "regime_weighted_arma_generator_unit_assert.svh"

module regime_weighted_arma_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port.
    input  logic                            cfg_write,
    input  logic [rwag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwag_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [rwag_pkg::COEF_IDX_W-1:0] coef_index,
    input  logic [rwag_pkg::DATA_W-1:0]     coef_value,
    input  logic [rwag_pkg::WEIGHT_W-1:0]   weight_0,
    input  logic [rwag_pkg::WEIGHT_W-1:0]   weight_1,
    input  logic [rwag_pkg::WEIGHT_W-1:0]   weight_2,
    input  logic [rwag_pkg::WEIGHT_W-1:0]   weight_3,
    input  logic [rwag_pkg::DATA_W-1:0]     mean_0,
    input  logic [rwag_pkg::DATA_W-1:0]     mean_1,
    input  logic [rwag_pkg::DATA_W-1:0]     mean_2,
    input  logic [rwag_pkg::DATA_W-1:0]     mean_3,
    input  logic [rwag_pkg::DATA_W-1:0]     shock,
    // Output channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rwag_pkg::DATA_W-1:0]     value,
    output logic                            saturated
);
    import rwag_pkg::*;

    logic [CFG_DATA_W-1:0] regime_count_reg;
    logic                  mean_adjust_reg;

    logic [WEIGHT_W-1:0] weight_reg [MAX_REGIMES];
    logic [DATA_W-1:0]   mean_reg   [MAX_REGIMES];
    logic [DATA_W-1:0]   shock_reg;

    logic [DATA_W-1:0] value_reg;
    logic              saturated_reg;
    logic              out_valid_reg;

    logic in_xfer;
    logic start_step;
    logic coef_wr;
    logic out_free;

    issue_t    issue;
    seq_ctrl_t ctrl;

    logic [DATA_W-1:0]        coef_rd;
    logic signed [OPND_W-1:0] hist_operand;
    logic [DATA_W-1:0]        result_value;
    logic                     result_sat;

    // Input transfer decode.
    assign in_stall   = ctrl.busy;
    assign in_xfer    = in_valid && !in_stall;
    assign start_step = in_xfer && (operation == OP_STEP);
    assign coef_wr    = in_xfer && (operation == OP_WRITE)
                        && (32'(coef_index) < TABLE_SIZE);
    assign out_free   = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regime_count_reg <= CFG_DATA_W'(1);
            mean_adjust_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REGIME_COUNT: regime_count_reg <= cfg_data;
                CFG_MEAN_ADJUST:  mean_adjust_reg  <= cfg_data[0];
                default:          mean_adjust_reg  <= mean_adjust_reg;
            endcase
        end
    end

    // Capture the step operands at the transfer.
    always_ff @(posedge clk)
    begin
        if (start_step)
        begin
            weight_reg[0] <= weight_0;
            weight_reg[1] <= weight_1;
            weight_reg[2] <= weight_2;
            weight_reg[3] <= weight_3;
            mean_reg[0]   <= mean_0;
            mean_reg[1]   <= mean_1;
            mean_reg[2]   <= mean_2;
            mean_reg[3]   <= mean_3;
            shock_reg     <= shock;
        end
    end

    rwag_coef_mem u_coef_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (coef_wr),
        .wr_addr (TABLE_ADDR_W'(coef_index)),
        .wr_data (coef_value),
        .rd_en   (issue.valid && (issue.kind == KIND_SHARED_TAP
                                  || issue.kind == KIND_REGIME_TAP)),
        .rd_addr (issue.coef_addr),
        .rd_data (coef_rd)
    );

    rwag_history u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .mean_adjust (mean_adjust_reg),
        .finish      (ctrl.finish),
        .new_output  (result_value),
        .new_mean    (mean_reg),
        .new_shock   (shock_reg),
        .operand     (hist_operand)
    );

    rwag_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .ctrl         (ctrl),
        .hist_operand (hist_operand),
        .coef         (coef_rd),
        .weight       (weight_reg),
        .mean         (mean_reg),
        .shock        (shock_reg),
        .result_value (result_value),
        .result_sat   (result_sat)
    );

    rwag_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_step   (start_step),
        .regime_count (regime_count_reg),
        .out_free     (out_free),
        .issue        (issue),
        .ctrl         (ctrl)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            value_reg     <= result_value;
            saturated_reg <= result_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = saturated_reg;

    // A clipped result sits at one of the two range limits.
    `RWAG_ASSERT_SAME(a_sat_limits, clk, rst_n, out_valid && saturated,
        value == 32'h7fff_ffff || value == 32'h8000_0000,
        "saturated result is not at a range limit")

    // A time step keeps the input side stalled while it is computed.
    `RWAG_ASSERT_NEXT(a_step_busy, clk, rst_n, start_step, in_stall,
        "input taken while a time step is in progress")

endmodule

`default_nettype wire
